>>> hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants and helpers for the text console cell writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = CHAR_W + ATTR_W;
    localparam int INDEX_W = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'h07;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    function automatic logic [CELL_W-1:0] make_cell(
        input logic [CHAR_W-1:0] ch,
        input logic [ATTR_W-1:0] attr
    );
        make_cell = {attr, ch};
    endfunction

endpackage

>>> hw/rtl/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/tcw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_engine
// sequencer for puts, reads, scrolling and the post-reset clearing pass
// ----------------------------------------------------------------------------
module tcw_engine #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [tcw_pkg::ATTR_W-1:0]            text_color,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_func,
    input  logic [tcw_pkg::CHAR_W-1:0]            in_char,
    input  logic [tcw_pkg::INDEX_W-1:0]           in_index,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [tcw_pkg::CELL_W-1:0]            out_data,
    output logic [tcw_pkg::ROW_OUT_W-1:0]         out_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]         out_col,
    output logic                                  mem_we,
    output logic [$clog2(ROWS*COLS)-1:0]          mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0]            mem_wdata,
    output logic                                  mem_re,
    output logic [$clog2(ROWS*COLS)-1:0]          mem_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]            mem_rdata
);

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_BLANK  = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [ROW_W-1:0]           cur_y_reg, cur_y_next;
    logic [COL_W-1:0]           cur_x_reg, cur_x_next;
    logic                       rd_ok_reg, rd_ok_next;
    logic [tcw_pkg::CELL_W-1:0] res_data_reg, res_data_next;
    logic                       wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]          wr_addr_reg, wr_addr_next;
    logic                       m_valid_reg, m_valid_next;
    logic [tcw_pkg::CELL_W-1:0] m_data_reg, m_data_next;
    logic [tcw_pkg::ROW_OUT_W-1:0] m_row_reg, m_row_next;
    logic [tcw_pkg::COL_OUT_W-1:0] m_col_reg, m_col_next;

    logic              accept;
    logic              in_range;
    logic              newline;
    logic [CNT_W-1:0]  cur_addr;
    logic [COL_W:0]    x_plus;
    logic [ROW_W:0]    y_plus;
    logic              slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign in_range  = (32'(in_index) < 32'(CELLS));
    assign newline   = (in_char == tcw_pkg::NEWLINE_CODE);
    assign cur_addr  = CNT_W'(CNT_W'(cur_y_reg) * CNT_W'(COLS)) + CNT_W'(cur_x_reg);
    assign x_plus    = (COL_W + 1)'(cur_x_reg) + 1'b1;
    assign y_plus    = (ROW_W + 1)'(cur_y_reg) + 1'b1;
    assign slot_free = !m_valid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cur_y_next    = cur_y_reg;
        cur_x_next    = cur_x_reg;
        rd_ok_next    = rd_ok_reg;
        res_data_next = res_data_reg;
        wr_pend_next  = wr_pend_reg;
        wr_addr_next  = wr_addr_reg;
        m_valid_next  = m_valid_reg && !out_ready;
        m_data_next   = m_data_reg;
        m_row_next    = m_row_reg;
        m_col_next    = m_col_reg;
        mem_we        = 1'b0;
        mem_waddr     = cur_addr[ADDR_W-1:0];
        mem_wdata     = tcw_pkg::make_cell(in_char, text_color);
        mem_re        = 1'b0;
        mem_raddr     = ADDR_W'(in_index);

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[ADDR_W-1:0];
                mem_wdata = tcw_pkg::make_cell(tcw_pkg::SPACE_CODE, tcw_pkg::RESET_COLOR);
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_func == tcw_pkg::FUNC_READ)
                    begin
                        mem_re     = in_range;
                        rd_ok_next = in_range;
                        state_next = ST_RDWAIT;
                    end
                    else
                    begin
                        res_data_next = '0;
                        mem_we        = !newline;
                        state_next    = ST_EMIT;
                        if (newline || x_plus >= (COL_W + 1)'(COLS))
                        begin
                            cur_x_next = '0;
                            if (y_plus >= (ROW_W + 1)'(ROWS))
                            begin
                                cur_y_next   = ROW_W'(ROWS - 1);
                                cnt_next     = '0;
                                wr_pend_next = 1'b0;
                                state_next   = ST_SCROLL;
                            end
                            else
                            begin
                                cur_y_next = y_plus[ROW_W-1:0];
                            end
                        end
                        else
                        begin
                            cur_x_next = x_plus[COL_W-1:0];
                        end
                    end
                end
            end
            ST_RDWAIT:
            begin
                res_data_next = rd_ok_reg ? mem_rdata : '0;
                state_next    = ST_EMIT;
            end
            ST_SCROLL:
            begin
                // read one row ahead, write the beat read last cycle
                mem_we    = wr_pend_reg;
                mem_waddr = wr_addr_reg;
                mem_wdata = mem_rdata;
                if (cnt_reg < CNT_W'(CELLS - COLS))
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = ADDR_W'(cnt_reg + CNT_W'(COLS));
                    wr_pend_next = 1'b1;
                    wr_addr_next = cnt_reg[ADDR_W-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    state_next   = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[ADDR_W-1:0];
                mem_wdata = tcw_pkg::make_cell(tcw_pkg::SPACE_CODE, text_color);
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_data_reg;
                    m_row_next   = tcw_pkg::ROW_OUT_W'(cur_y_reg);
                    m_col_next   = tcw_pkg::COL_OUT_W'(cur_x_reg);
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            cur_y_reg   <= '0;
            cur_x_reg   <= '0;
            rd_ok_reg   <= 1'b0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cur_y_reg   <= cur_y_next;
            cur_x_reg   <= cur_x_next;
            rd_ok_reg   <= rd_ok_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
        wr_addr_reg  <= wr_addr_next;
        m_data_reg   <= m_data_next;
        m_row_reg    <= m_row_next;
        m_col_reg    <= m_col_next;
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;
    assign out_row   = m_row_reg;
    assign out_col   = m_col_reg;

endmodule

>>> hw/rtl/text_console_cell_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit
// text-mode console: ROWS x COLS cell store with cursor, put, read and scroll
// ----------------------------------------------------------------------------
// The cell store sits in one simple dual-port RAM, one cell per cycle on its
// write port. After reset the block runs a clearing pass over all ROWS*COLS
// cells that fills every cell with grey spaces; no beat is accepted until it
// ends, while color writes are taken at any time. A read beat passes the
// read-wait and emit states, a put or newline only the emit state, which
// loads the output register once it is free. A put or newline that moves
// below the bottom row also scrolls the store before the emit state, one
// cell per cycle through the RAM: row copies, then bottom-row blanking. The
// next beat is accepted while a result still waits in the output register.
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,     // text_color
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // char_code[7:0], cell_index[18:8], zero pad
    input  logic        s_tuser,       // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // cell_data[15:0], cursor_row[20:16],
                                       // cursor_column[27:21], zero pad
);

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [tcw_pkg::ATTR_W-1:0]    text_color_reg;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]    mem_wdata;
    logic                          mem_re;
    logic [ADDR_W-1:0]             mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]    mem_rdata;
    logic [tcw_pkg::CELL_W-1:0]    out_data;
    logic [tcw_pkg::ROW_OUT_W-1:0] out_row;
    logic [tcw_pkg::COL_OUT_W-1:0] out_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= tcw_pkg::RESET_COLOR;
        end
        else if (cfg_we)
        begin
            text_color_reg <= cfg_wdata;
        end
    end

    tcw_engine #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_color (text_color_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_char    (s_tdata[7:0]),
        .in_index   (s_tdata[18:8]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data),
        .out_row    (out_row),
        .out_col    (out_col),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_tdata = {4'b0, out_col, out_row, out_data};

endmodule

>>> sim/tb_text_console_cell_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer_unit
// self-checking bench for the text console cell writer: a directed table of
// reads, puts and newlines from reset, then phases of random text lines with
// reads mixed in, each phase under a new text color. A shadow copy of the
// cell store and cursor predicts each beat the directed table leaves open,
// including line wraps and scrolls; every beat is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_text_console_cell_writer_unit;

    localparam int ROWS_N      = tcw_pkg::ROWS_DEF;
    localparam int COLS_N      = tcw_pkg::COLS_DEF;
    localparam int CELLS       = ROWS_N * COLS_N;
    localparam int MAX_GAP     = 12;
    localparam int MAX_STALL   = 12;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 20;
    localparam int ITEM_BUDGET = 900;
    localparam int CYCLE_LIMIT = 3 * (CELLS + 2 * LONG_HOLD
                                 + ITEM_BUDGET * (CELLS + 8 + MAX_GAP + MAX_STALL));
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 125;
    localparam int DIR_N       = 23;

    typedef struct packed {
        logic [tcw_pkg::COL_OUT_W-1:0] col;
        logic [tcw_pkg::ROW_OUT_W-1:0] row;
        logic [tcw_pkg::CELL_W-1:0]    cell_data;
    } console_beat_t;

    typedef struct packed {
        logic                          func;
        logic [tcw_pkg::CHAR_W-1:0]    ch;
        logic [tcw_pkg::INDEX_W-1:0]   idx;
        logic                          known;
        logic [tcw_pkg::CELL_W-1:0]    cell_data;
        logic [tcw_pkg::ROW_OUT_W-1:0] row;
        logic [tcw_pkg::COL_OUT_W-1:0] col;
    } directed_row_t;

    // known rows carry the result that follows directly from reset state
    localparam directed_row_t DIRECTED [DIR_N] = '{
        '{tcw_pkg::FUNC_READ, 8'h00, 11'd0,    1'b1, 16'h0720, 5'd0, 7'd0},
        '{tcw_pkg::FUNC_READ, 8'hFF, 11'd1999, 1'b1, 16'h0720, 5'd0, 7'd0},
        '{tcw_pkg::FUNC_READ, 8'h00, 11'd2000, 1'b1, 16'h0000, 5'd0, 7'd0},
        '{tcw_pkg::FUNC_READ, 8'h00, 11'd2047, 1'b1, 16'h0000, 5'd0, 7'd0},
        '{tcw_pkg::FUNC_PUT,  8'h41, 11'd2047, 1'b1, 16'h0000, 5'd0, 7'd1},
        '{tcw_pkg::FUNC_PUT,  8'h00, 11'd0,    1'b1, 16'h0000, 5'd0, 7'd2},
        '{tcw_pkg::FUNC_PUT,  8'hFF, 11'd0,    1'b1, 16'h0000, 5'd0, 7'd3},
        '{tcw_pkg::FUNC_PUT,  8'h20, 11'd0,    1'b1, 16'h0000, 5'd0, 7'd4},
        '{tcw_pkg::FUNC_READ, 8'h00, 11'd0,    1'b1, 16'h0741, 5'd0, 7'd4},
        '{tcw_pkg::FUNC_READ, 8'h00, 11'd1,    1'b1, 16'h0700, 5'd0, 7'd4},
        '{tcw_pkg::FUNC_READ, 8'h00, 11'd2,    1'b1, 16'h07FF, 5'd0, 7'd4},
        '{tcw_pkg::FUNC_READ, 8'h00, 11'd4,    1'b1, 16'h0720, 5'd0, 7'd4},
        '{tcw_pkg::FUNC_PUT,  8'h0A, 11'd0,    1'b1, 16'h0000, 5'd1, 7'd0},
        '{tcw_pkg::FUNC_READ, 8'h00, 11'd4,    1'b1, 16'h0720, 5'd1, 7'd0},
        '{tcw_pkg::FUNC_PUT,  8'h0A, 11'd0,    1'b1, 16'h0000, 5'd2, 7'd0},
        '{tcw_pkg::FUNC_PUT,  8'h0B, 11'd0,    1'b1, 16'h0000, 5'd2, 7'd1},
        '{tcw_pkg::FUNC_PUT,  8'h09, 11'd0,    1'b1, 16'h0000, 5'd2, 7'd2},
        '{tcw_pkg::FUNC_PUT,  8'h0A, 11'd0,    1'b1, 16'h0000, 5'd3, 7'd0},
        '{tcw_pkg::FUNC_READ, 8'h00, 11'd160,  1'b1, 16'h070B, 5'd3, 7'd0},
        '{tcw_pkg::FUNC_READ, 8'h00, 11'd161,  1'b1, 16'h0709, 5'd3, 7'd0},
        '{tcw_pkg::FUNC_PUT,  8'h7E, 11'h555,  1'b0, 16'h0000, 5'd0, 7'd0},
        '{tcw_pkg::FUNC_READ, 8'h55, 11'd240,  1'b0, 16'h0000, 5'd0, 7'd0},
        '{tcw_pkg::FUNC_PUT,  8'h80, 11'h2AA,  1'b0, 16'h0000, 5'd0, 7'd0}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    // shadow of the console
    logic [tcw_pkg::CELL_W-1:0] shadow_cells [CELLS];
    int unsigned                cur_row;
    int unsigned                cur_col;
    logic [tcw_pkg::ATTR_W-1:0] shadow_color;

    console_beat_t expected_beats [$];
    console_beat_t got_beat;
    console_beat_t want_beat;

    int unsigned cycle_count = 0;
    int unsigned n_errors    = 0;
    int unsigned n_results   = 0;
    int unsigned n_puts      = 0;
    int unsigned n_newlines  = 0;
    int unsigned n_wraps     = 0;
    int unsigned n_scrolls   = 0;
    int unsigned n_reads     = 0;
    int unsigned n_oor_reads = 0;
    int unsigned n_colors    = 0;
    int unsigned n_holds     = 0;
    int unsigned line_left   = 0;
    bit          hold_req    = 1'b0;

    text_console_cell_writer_unit #(
        .ROWS (ROWS_N),
        .COLS (COLS_N)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL text_console_cell_writer_unit");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        n_errors++;
        if (n_errors <= 40)
            $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                     $time, n_results, what, got_v, want_v);
    endtask

    task automatic clear_console();
        for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::SPACE_CODE};
        cur_row      = 0;
        cur_col      = 0;
        shadow_color = tcw_pkg::RESET_COLOR;
    endtask

    task automatic scroll_console();
        for (int i = 0; i + COLS_N < CELLS; i++)
            shadow_cells[i] = shadow_cells[i + COLS_N];
        for (int i = CELLS - COLS_N; i < CELLS; i++)
            shadow_cells[i] = {shadow_color, tcw_pkg::SPACE_CODE};
        n_scrolls++;
    endtask

    task automatic predict_console(input logic func, input logic [tcw_pkg::CHAR_W-1:0] ch,
                                   input logic [tcw_pkg::INDEX_W-1:0] idx,
                                   output console_beat_t r);
        r = '0;
        if (func == tcw_pkg::FUNC_READ)
        begin
            n_reads++;
            if (idx < CELLS)
                r.cell_data = shadow_cells[idx];
            else
                n_oor_reads++;
        end
        else
        begin
            if (ch == tcw_pkg::NEWLINE_CODE)
                n_newlines++;
            else
            begin
                n_puts++;
                shadow_cells[cur_row * COLS_N + cur_col] = {shadow_color, ch};
            end
            if (ch == tcw_pkg::NEWLINE_CODE || cur_col == COLS_N - 1)
            begin
                if (ch != tcw_pkg::NEWLINE_CODE)
                    n_wraps++;
                cur_col = 0;
                if (cur_row == ROWS_N - 1)
                    scroll_console();
                else
                    cur_row++;
            end
            else
                cur_col++;
        end
        r.row = tcw_pkg::ROW_OUT_W'(cur_row);
        r.col = tcw_pkg::COL_OUT_W'(cur_col);
    endtask

    task automatic send_beat(input logic func, input logic [tcw_pkg::CHAR_W-1:0] ch,
                             input logic [tcw_pkg::INDEX_W-1:0] idx, input logic known,
                             input console_beat_t known_beat);
        console_beat_t predicted;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {5'b0, idx, ch};
        do
            @(posedge clk);
        while (!s_tready);
        predict_console(func, ch, idx, predicted);
        expected_beats.push_back(known ? known_beat : predicted);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic drain_results();
        idle_sender(1);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_color(input logic [tcw_pkg::ATTR_W-1:0] color);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= color;
        @(posedge clk);
        shadow_color = color;
        n_colors++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int unsigned pick_line_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom_range(0, 6);
        else if (roll < 88)
            return $urandom_range(7, 30);
        else
            return $urandom_range(COLS_N, COLS_N + 40);
    endfunction

    // text lines ended by newlines, with long lines that wrap and reads mixed in
    task automatic send_random_item();
        logic                         func;
        logic [tcw_pkg::CHAR_W-1:0]   ch;
        logic [tcw_pkg::INDEX_W-1:0]  idx;
        int unsigned                  roll;
        roll = $urandom_range(0, 99);
        ch   = tcw_pkg::CHAR_W'($urandom_range(0, 255));
        idx  = tcw_pkg::INDEX_W'($urandom_range(0, 2047));
        if (roll < 30)
        begin
            func = tcw_pkg::FUNC_READ;
            if (roll < 15)
                idx = tcw_pkg::INDEX_W'(cur_row * COLS_N + $urandom_range(0, COLS_N - 1));
            else if (roll < 27)
                idx = tcw_pkg::INDEX_W'($urandom_range(0, CELLS - 1));
        end
        else if (line_left == 0)
        begin
            func      = tcw_pkg::FUNC_PUT;
            ch        = tcw_pkg::NEWLINE_CODE;
            line_left = pick_line_len();
        end
        else
        begin
            func = tcw_pkg::FUNC_PUT;
            if ($urandom_range(0, 9) != 0)
                ch = tcw_pkg::CHAR_W'($urandom_range(32'h20, 32'h7E));
            line_left--;
        end
        send_beat(func, ch, idx, 1'b0, '0);
    endtask

    task automatic run_phase(input int n_items, input logic [tcw_pkg::ATTR_W-1:0] color,
                             input bit with_hold);
        int unsigned burst_left;
        int unsigned gapless_left;
        drain_results();
        burst_left   = 0;
        gapless_left = 0;
        if (with_hold)
        begin
            hold_req     = 1'b1;
            gapless_left = 60;
        end
        write_color(color);
        repeat (n_items)
        begin
            if (gapless_left > 0)
                gapless_left--;
            else if (burst_left == 0)
            begin
                if ($urandom_range(0, 9) < 7)
                    idle_sender($urandom_range(1, MAX_GAP));
                burst_left = $urandom_range(1, 20);
            end
            if (burst_left > 0)
                burst_left--;
            send_random_item();
        end
    endtask

    // receiver stall pattern, with one long hold on request
    initial
    begin : receiver
        int unsigned tick;
        int unsigned mode;
        int unsigned mode_left;
        m_tready  = 1'b0;
        tick      = 0;
        mode      = 0;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_req = 1'b0;
                n_holds++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 40);
                end
                mode_left--;
                tick++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= (tick % 3 != 0);
                    2:       m_tready <= ($urandom_range(0, 99) >= 40);
                    default: m_tready <= (tick % MAX_STALL < 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            got_beat = m_tdata[27:0];
            if (expected_beats.size() == 0)
                report_mismatch("beat with nothing expected", m_tdata, 32'h0);
            else
            begin
                want_beat = expected_beats.pop_front();
                if (got_beat.cell_data !== want_beat.cell_data)
                    report_mismatch("cell_data", 32'(got_beat.cell_data),
                                    32'(want_beat.cell_data));
                if (got_beat.row !== want_beat.row)
                    report_mismatch("cursor_row", 32'(got_beat.row), 32'(want_beat.row));
                if (got_beat.col !== want_beat.col)
                    report_mismatch("cursor_column", 32'(got_beat.col), 32'(want_beat.col));
            end
            if (m_tdata[31:28] !== 4'h0)
                report_mismatch("pad bits", 32'(m_tdata[31:28]), 32'h0);
        end
    end

    initial
    begin
        console_beat_t known_beat;
        logic [tcw_pkg::ATTR_W-1:0] phase_colors [PHASES];
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 8'h00;
        s_tvalid  = 1'b0;
        s_tdata   = 24'h0;
        s_tuser   = 1'b0;
        clear_console();
        phase_colors[0] = 8'h00;
        phase_colors[1] = 8'hFF;
        phase_colors[2] = 8'h1F;
        phase_colors[3] = tcw_pkg::ATTR_W'($urandom_range(0, 255));
        phase_colors[4] = 8'hF0;
        phase_colors[5] = tcw_pkg::ATTR_W'($urandom_range(0, 255));
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < DIR_N; k++)
        begin
            known_beat.cell_data = DIRECTED[k].cell_data;
            known_beat.row       = DIRECTED[k].row;
            known_beat.col       = DIRECTED[k].col;
            send_beat(DIRECTED[k].func, DIRECTED[k].ch, DIRECTED[k].idx,
                      DIRECTED[k].known, known_beat);
            if ($urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 4));
        end

        for (int p = 0; p < PHASES; p++)
            run_phase(PHASE_ITEMS, phase_colors[p], p == 2);

        idle_sender(1);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("run: %0d chars, %0d newlines, %0d wraps, %0d scrolls, %0d color settings",
                 n_puts, n_newlines, n_wraps, n_scrolls, n_colors);
        $display("run: %0d reads (%0d past the store), %0d results, %0d long output holds",
                 n_reads, n_oor_reads, n_results, n_holds);
        if (n_errors == 0)
            $display("PASS text_console_cell_writer_unit");
        else
            $display("FAIL text_console_cell_writer_unit");
        $finish;
    end

endmodule
